// ===== rtl/core/trsr_pkg.sv =====
// Shared types and constants for the timed relay shift register driver.
// No dependencies; imported by every module of the core.
package trsr_pkg;

   localparam int NUM_RELAYS   = 8;
   localparam int FRAME_BYTES  = 3;
   localparam int FRAME_BITS   = 8 * FRAME_BYTES;
   localparam int BIT_CNT_W    = $clog2(FRAME_BITS + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W       = 2;
   localparam int INDEX_W      = 3;
   localparam int DURATION_W   = 32;
   localparam int COUNT_W      = 4;
   localparam int IMAGE_W      = 8;

   localparam logic [KIND_W-1:0] KIND_ON    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFF   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TIMED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

   localparam logic [COUNT_W-1:0] RELAY_COUNT_RESET = 4'd8;

   // front to queue: one frame request carrying the image to send
   typedef struct packed {
      logic               push;
      logic [IMAGE_W-1:0] image;
   } queue_wr_type;

   // queue to back and top: head of the queue and fill status
   typedef struct packed {
      logic               valid;
      logic               full;
      logic [IMAGE_W-1:0] image;
   } queue_rd_type;

endpackage

// ===== rtl/core/trsr_front.sv =====
// Command front end: relay image, per-relay countdown timers, relay count register.
// Depends on trsr_pkg; pushes one frame request into the queue per frame.
module trsr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [trsr_pkg::KIND_W-1:0]     kind,
   input  logic [trsr_pkg::INDEX_W-1:0]    relay_index,
   input  logic [trsr_pkg::DURATION_W-1:0] duration_ticks,
   input  logic                            cfg_write,
   input  logic [trsr_pkg::COUNT_W-1:0]    cfg_data,
   output trsr_pkg::queue_wr_type          q_wr
);
   import trsr_pkg::*;

   logic [COUNT_W-1:0]    relay_count_ff;
   logic [IMAGE_W-1:0]    relay_bits_ff, relay_bits_in;
   logic [NUM_RELAYS-1:0] running_ff, running_in;
   logic [DURATION_W-1:0] remaining_ff [NUM_RELAYS];
   logic [DURATION_W-1:0] remaining_in [NUM_RELAYS];

   logic [COUNT_W-1:0]    used;
   logic                  index_ok;
   logic                  expired;

   assign used     = (relay_count_ff > COUNT_W'(NUM_RELAYS)) ? COUNT_W'(NUM_RELAYS)
                                                             : relay_count_ff;
   assign index_ok = {{(COUNT_W-INDEX_W){1'b0}}, relay_index} < used;

   always_comb begin
      relay_bits_in = relay_bits_ff;
      running_in    = running_ff;
      expired       = 1'b0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
         remaining_in[i] = remaining_ff[i];
      end
      if (accept) begin
         if (kind == KIND_TICK) begin
            // each lane counts down on its own; a count of 0 or 1 expires
            for (int i = 0; i < NUM_RELAYS; i++) begin
               if (running_ff[i]) begin
                  if (remaining_ff[i] <= DURATION_W'(1)) begin
                     running_in[i]    = 1'b0;
                     remaining_in[i]  = '0;
                     relay_bits_in[i] = 1'b0;
                     expired          = 1'b1;
                  end else begin
                     remaining_in[i] = remaining_ff[i] - DURATION_W'(1);
                  end
               end
            end
         end else if (index_ok) begin
            for (int i = 0; i < NUM_RELAYS; i++) begin
               if (relay_index == INDEX_W'(i)) begin
                  relay_bits_in[i] = (kind != KIND_OFF);
                  if (kind == KIND_TIMED) begin
                     running_in[i]   = 1'b1;
                     remaining_in[i] = duration_ticks;
                  end
               end
            end
         end
      end
   end

   assign q_wr.push  = accept && ((kind == KIND_TICK) ? expired : index_ok);
   assign q_wr.image = relay_bits_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_count_ff <= RELAY_COUNT_RESET;
         relay_bits_ff  <= '0;
         running_ff     <= '0;
         for (int i = 0; i < NUM_RELAYS; i++) begin
            remaining_ff[i] <= '0;
         end
      end else begin
         if (cfg_write) begin
            relay_count_ff <= cfg_data;
         end
         relay_bits_ff <= relay_bits_in;
         running_ff    <= running_in;
         for (int i = 0; i < NUM_RELAYS; i++) begin
            remaining_ff[i] <= remaining_in[i];
         end
      end
   end

endmodule

// ===== rtl/core/trsr_queue.sv =====
// Short frame request queue between front and back (first-word fall-through).
// Depends on trsr_pkg.
module trsr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  trsr_pkg::queue_wr_type q_wr,
   input  logic                   pop,
   output trsr_pkg::queue_rd_type q_rd
);
   import trsr_pkg::*;

   logic [IMAGE_W-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = q_wr.push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   assign q_rd.valid = (count_ff != '0);
   assign q_rd.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_rd.image = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wr.image;
      end
   end

endmodule

// ===== rtl/core/trsr_back.sv =====
// Frame shifter: turns one queued image into frame bit words and a latch word.
// Depends on trsr_pkg; reads the head of trsr_queue.
module trsr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  trsr_pkg::queue_rd_type       q_rd,
   output logic                         q_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic                         rsp_serial_bit,
   output logic                         rsp_latch_pulse,
   output logic [trsr_pkg::IMAGE_W-1:0] rsp_relay_image,
   output logic                         rsp_last
);
   import trsr_pkg::*;

   logic                 busy_ff;
   logic [BIT_CNT_W-1:0] cnt_ff;
   logic [IMAGE_W-1:0]   image_ff;
   logic                 at_latch;
   logic                 done;

   assign at_latch = (cnt_ff == BIT_CNT_W'(FRAME_BITS));
   assign done     = busy_ff && rsp_pop && at_latch;
   // load the next frame when idle or as the latch word leaves
   assign q_pop    = q_rd.valid && (!busy_ff || done);

   assign rsp_empty       = !busy_ff;
   assign rsp_relay_image = image_ff;
   assign rsp_latch_pulse = at_latch;
   assign rsp_last        = at_latch;
   // only the first byte carries data, the padding bytes shift zeros
   assign rsp_serial_bit  = (cnt_ff < BIT_CNT_W'(8)) ? image_ff[3'd7 - cnt_ff[2:0]] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (q_pop) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && rsp_pop) begin
         cnt_ff <= cnt_ff + BIT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         image_ff <= q_rd.image;
      end
   end

endmodule

// ===== rtl/core/timed_relay_shift_register_driver_core.sv =====
// Top level of the timed relay shift register driver.
// Depends on trsr_pkg, trsr_front, trsr_queue and trsr_back.
//
//   channel  direction  handshake              payload
//   req      in         push / full            kind, relay_index, duration_ticks
//   rsp      out        empty / pop            serial_bit, latch_pulse, relay_image, last
//   csr      in         valid / ready          data (relay count)
//
// The front takes one command per cycle while the 4-entry frame queue has room.
// Each frame is 25 words (24 frame bits plus the latch word), one per cycle from
// the back shifter while rsp_pop is high; commands that send frames are paced by it.
// Synchronous reset: image off, timers stopped, relay count 8, queue empty.
// A stalled rsp side fills the queue and then raises req_full; csr is always ready.
module timed_relay_shift_register_driver_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [trsr_pkg::KIND_W-1:0]     req_kind,
   input  logic [trsr_pkg::INDEX_W-1:0]    req_relay_index,
   input  logic [trsr_pkg::DURATION_W-1:0] req_duration_ticks,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_serial_bit,
   output logic                            rsp_latch_pulse,
   output logic [trsr_pkg::IMAGE_W-1:0]    rsp_relay_image,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [trsr_pkg::COUNT_W-1:0]    csr_data
);
   import trsr_pkg::*;

   queue_wr_type q_wr;
   queue_rd_type q_rd;
   logic         q_pop;
   logic         accept;

   assign req_full  = q_rd.full;
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   trsr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_kind),
      .relay_index    (req_relay_index),
      .duration_ticks (req_duration_ticks),
      .cfg_write      (csr_valid && csr_ready),
      .cfg_data       (csr_data),
      .q_wr           (q_wr)
   );

   trsr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .q_rd  (q_rd)
   );

   trsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_rd            (q_rd),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_pulse (rsp_latch_pulse),
      .rsp_relay_image (rsp_relay_image),
      .rsp_last        (rsp_last)
   );

   // mid-frame words keep the shifter busy on the same image
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last) |=> !rsp_empty)
      else $error("frame cut short");

   a_image_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last) |=> $stable(rsp_relay_image))
      else $error("image changed inside a frame");

   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      (q_wr.push && !q_rd.full) |=> q_rd.valid)
      else $error("frame request lost");

   a_latch_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_latch_pulse) |-> !rsp_serial_bit)
      else $error("data bit on latch word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for timed_relay_shift_register_driver_core.
// Depends on trsr_pkg and the core RTL. It predicts every frame word from its
// own copy of the relay image, the timers and the relay count.
module tb;
   import trsr_pkg::*;

   typedef struct packed {
      logic               serial_bit;
      logic               latch_pulse;
      logic [IMAGE_W-1:0] image;
      logic               last;
   } relay_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [KIND_W-1:0]     req_kind = KIND_ON;
   logic [INDEX_W-1:0]    req_relay_index = '0;
   logic [DURATION_W-1:0] req_duration_ticks = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_serial_bit;
   logic                  rsp_latch_pulse;
   logic [IMAGE_W-1:0]    rsp_relay_image;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data = '0;

   // predicted block state
   logic [COUNT_W-1:0]    count_shadow = RELAY_COUNT_RESET;
   logic [IMAGE_W-1:0]    image_shadow = '0;
   logic                  timer_on [NUM_RELAYS];
   logic [DURATION_W-1:0] timer_left [NUM_RELAYS];

   relay_word_type frame_words_q[$];
   int             mismatches = 0;
   bit             calm = 1'b0;      // no random idling on either side
   int             pop_hold = 0;     // receiver hold-off, in cycles

   timed_relay_shift_register_driver_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_kind           (req_kind),
      .req_relay_index    (req_relay_index),
      .req_duration_ticks (req_duration_ticks),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_serial_bit     (rsp_serial_bit),
      .rsp_latch_pulse    (rsp_latch_pulse),
      .rsp_relay_image    (rsp_relay_image),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("timed_relay_shift_register_driver_core: mismatch");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns: %s", $realtime, what);
      end
   endtask

   // applies one accepted command and queues the frame it sends, if any
   function automatic void predict_frames(input logic [KIND_W-1:0] kind,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [DURATION_W-1:0] dur);
      int             used;
      bit             send;
      relay_word_type w;
      used = (int'(count_shadow) > NUM_RELAYS) ? NUM_RELAYS : int'(count_shadow);
      send = 1'b0;
      if (kind == KIND_TICK) begin
         for (int i = 0; i < NUM_RELAYS; i++) begin
            if (timer_on[i]) begin
               if (timer_left[i] <= 1) begin
                  timer_on[i] = 1'b0;
                  timer_left[i] = '0;
                  image_shadow[i] = 1'b0;
                  send = 1'b1;
               end else begin
                  timer_left[i] = timer_left[i] - 1;
               end
            end
         end
      end else if (int'(idx) < used) begin
         send = 1'b1;
         if (kind == KIND_OFF) begin
            image_shadow[idx] = 1'b0;
         end else begin
            image_shadow[idx] = 1'b1;
            if (kind == KIND_TIMED) begin
               timer_on[idx] = 1'b1;
               timer_left[idx] = dur;
            end
         end
      end
      if (send) begin
         // image byte MSB first, then the zero bytes, then the latch word
         for (int b = FRAME_BITS - 1; b >= 0; b--) begin
            w.serial_bit  = (b >= FRAME_BITS - IMAGE_W) ?
                            image_shadow[b - (FRAME_BITS - IMAGE_W)] : 1'b0;
            w.latch_pulse = 1'b0;
            w.image       = image_shadow;
            w.last        = 1'b0;
            frame_words_q.push_back(w);
         end
         w.serial_bit  = 1'b0;
         w.latch_pulse = 1'b1;
         w.image       = image_shadow;
         w.last        = 1'b1;
         frame_words_q.push_back(w);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      relay_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frame_words_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected word bit=%0b latch=%0b image=%02h last=%0b",
                          rsp_serial_bit, rsp_latch_pulse, rsp_relay_image, rsp_last));
         end else begin
            want = frame_words_q.pop_front();
            if (rsp_serial_bit !== want.serial_bit || rsp_latch_pulse !== want.latch_pulse ||
                rsp_relay_image !== want.image || rsp_last !== want.last) begin
               flag_mismatch($sformatf(
                  "word exp bit=%0b latch=%0b image=%02h last=%0b got %0b %0b %02h %0b",
                  want.serial_bit, want.latch_pulse, want.image, want.last,
                  rsp_serial_bit, rsp_latch_pulse, rsp_relay_image, rsp_last));
            end
         end
      end
   end

   // receiver: random idling plus an occasional long hold-off
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         pop_hold = pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic send_command(input logic [KIND_W-1:0] kind,
                               input logic [INDEX_W-1:0] idx,
                               input logic [DURATION_W-1:0] dur);
      if (!calm && $urandom_range(0, 99) < 12) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_push           <= 1'b1;
      req_kind           <= kind;
      req_relay_index    <= idx;
      req_duration_ticks <= dur;
      do @(posedge clock); while (req_full);
      predict_frames(kind, idx, dur);
   endtask

   // drop push, wait for every expected word, then let ignored commands drain
   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (frame_words_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_relay_count(input logic [COUNT_W-1:0] n);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= n;
      do @(posedge clock); while (!csr_ready);
      count_shadow = n;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_command();
      logic [KIND_W-1:0]     kind;
      logic [DURATION_W-1:0] dur;
      int                    r;
      r = $urandom_range(0, 99);
      kind = (r < 35) ? KIND_TICK : (r < 60) ? KIND_TIMED : (r < 80) ? KIND_ON : KIND_OFF;
      r = $urandom_range(0, 9);
      if (r < 8) dur = $urandom_range(0, 12);
      else if (r == 8) dur = $urandom;
      else dur = 32'hFFFF_FFFF;
      send_command(kind, INDEX_W'($urandom_range(0, NUM_RELAYS - 1)), dur);
   endtask

   task automatic test_commands();
      send_command(KIND_TICK, 3'd0, 32'd0);    // quiet tick, no frame
      send_command(KIND_ON, 3'd0, 32'd0);
      send_command(KIND_ON, 3'd7, 32'hFFFF_FFFF);
      send_command(KIND_OFF, 3'd7, 32'd0);
      send_command(KIND_ON, 3'd0, 32'd0);      // image unchanged, frame still sent
      send_command(KIND_OFF, 3'd6, 32'd0);
   endtask

   task automatic test_timers();
      send_command(KIND_TIMED, 3'd3, 32'd0);
      send_command(KIND_TICK, 3'd7, 32'd0);
      send_command(KIND_TIMED, 3'd5, 32'd1);
      send_command(KIND_TIMED, 3'd6, 32'd2);
      send_command(KIND_TICK, 3'd0, 32'd0);
      send_command(KIND_TICK, 3'd0, 32'd0);
      // plain on/off leave the timer running; expiry still sends a frame
      send_command(KIND_TIMED, 3'd1, 32'd3);
      send_command(KIND_ON, 3'd1, 32'd0);
      send_command(KIND_OFF, 3'd1, 32'd0);
      repeat (3) send_command(KIND_TICK, 3'd5, 32'd0);
      send_command(KIND_TIMED, 3'd2, 32'hFFFF_FFFF);
      send_command(KIND_TIMED, 3'd4, 32'hA5A5_5A5A);
      // two expiries on one tick give one frame
      send_command(KIND_TIMED, 3'd0, 32'd1);
      send_command(KIND_TIMED, 3'd7, 32'd1);
      send_command(KIND_TICK, 3'd0, 32'd0);
   endtask

   task automatic test_relay_count();
      write_relay_count(4'd3);
      send_command(KIND_ON, 3'd3, 32'd0);      // index out of use
      send_command(KIND_TIMED, 3'd2, 32'd2);
      write_relay_count(4'd0);
      send_command(KIND_ON, 3'd0, 32'd0);
      send_command(KIND_TICK, 3'd0, 32'd0);
      send_command(KIND_TICK, 3'd0, 32'd0);    // clears relay 2 even with count 0
      write_relay_count(4'd15);                // acts as eight
      send_command(KIND_ON, 3'd7, 32'd0);
      send_command(KIND_TIMED, 3'd7, 32'd0);
      send_command(KIND_TICK, 3'd0, 32'd0);
   endtask

   task automatic test_backpressure();
      write_relay_count(4'd8);
      pop_hold = 400;
      for (int i = 0; i < 14; i++) begin
         send_command((i % 2) ? KIND_OFF : KIND_ON,
                      INDEX_W'($urandom_range(0, NUM_RELAYS - 1)), $urandom);
      end
      wait_idle();
   endtask

   task automatic test_random();
      logic [COUNT_W-1:0] counts [5];
      counts = '{4'd8, 4'd5, 4'd15, 4'd1, 4'd8};
      for (int p = 0; p < 5; p++) begin
         write_relay_count(counts[p]);
         calm = (p == 2);
         for (int i = 0; i < 17; i++) begin
            if (p == 1 && i == 13) wait_idle();
            send_random_command();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NUM_RELAYS; i++) begin
         timer_on[i] = 1'b0;
         timer_left[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_commands();
      test_timers();
      test_relay_count();
      test_backpressure();
      test_random();

      @(negedge clock);
      req_push <= 1'b0;
      for (int n = 0; n < 50000 && frame_words_q.size() != 0; n++) @(posedge clock);
      if (frame_words_q.size() != 0) begin
         flag_mismatch($sformatf("%0d words never arrived", frame_words_q.size()));
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("timed_relay_shift_register_driver_core: match");
      end else begin
         $display("timed_relay_shift_register_driver_core: mismatch");
      end
      $finish;
   end

endmodule
